// ----- rtl/vrfh_pkg.sv -----
`timescale 1ns / 1ps
package vrfh_pkg;

  // default build values
  localparam int DEF_VOL_DIM    = 64;
  localparam int DEF_STEP_LIMIT = 512;
  localparam int DEF_VOXEL_BITS = 8;

  // fixed field widths
  localparam int COORD_W   = 6;
  localparam int VALUE_W   = 8;
  localparam int START_W   = 20;
  localparam int DIR_W     = 16;
  localparam int THR_W     = 8;
  localparam int STEPS_W   = 10;
  localparam int SIZE_W    = 7;
  localparam int HIT_W     = 12;
  localparam int FRAC_W    = 14;
  localparam int START_FRAC_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int S_TDATA_W = 88;
  localparam int M_TDATA_W = 48;

  // register reset values
  localparam logic signed [DIR_W-1:0] RST_DIR_X   = 16'sd16384;
  localparam logic signed [DIR_W-1:0] RST_DIR_Y   = 16'sd0;
  localparam logic signed [DIR_W-1:0] RST_DIR_Z   = 16'sd0;
  localparam logic [THR_W-1:0]        RST_THR     = 8'd70;
  localparam logic [STEPS_W-1:0]      RST_STEPS   = 10'd512;
  localparam logic [SIZE_W-1:0]       RST_SIZE    = 7'd64;

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CAST  = 1'b1;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIR_X  = 3'd0,
    CFG_DIR_Y  = 3'd1,
    CFG_DIR_Z  = 3'd2,
    CFG_THR    = 3'd3,
    CFG_STEPS  = 3'd4,
    CFG_SIZE_X = 3'd5,
    CFG_SIZE_Y = 3'd6,
    CFG_SIZE_Z = 3'd7
  } cfg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic write;
    logic start;
    logic run;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic done;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/vrfh_ram.sv -----
`timescale 1ns / 1ps
module vrfh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- rtl/vrfh_ctrl.sv -----
`timescale 1ns / 1ps
module vrfh_ctrl import vrfh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic req_kind,
  input  sts_t sts,
  output logic s_tready,
  output cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_CAST
  } state_t;

  state_t state;
  logic   accept;
  logic   fin;

  assign accept = s_tvalid && s_tready;
  assign fin    = sts.hit || sts.done;

  // command decode
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.write = accept && (req_kind == REQ_WRITE);
        cmd.start = accept && (req_kind == REQ_CAST);
      end
      ST_CAST: begin
        cmd.run      = !fin;
        cmd.load_out = fin && sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

  // state and ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s_tready <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.start) begin
            state    <= ST_CAST;
            s_tready <= 1'b0;
          end
        end
        ST_CAST: begin
          if (cmd.load_out) begin
            state    <= ST_IDLE;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_IDLE;
          s_tready <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ----- rtl/vrfh_datapath.sv -----
`timescale 1ns / 1ps
module vrfh_datapath import vrfh_pkg::*; #(
  parameter int VOL_DIM    = DEF_VOL_DIM,
  parameter int STEP_LIMIT = DEF_STEP_LIMIT,
  parameter int VOXEL_BITS = DEF_VOXEL_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  input  logic [COORD_W-1:0]        wr_x,
  input  logic [COORD_W-1:0]        wr_y,
  input  logic [COORD_W-1:0]        wr_z,
  input  logic [VALUE_W-1:0]        wr_value,
  input  logic signed [START_W-1:0] start_x,
  input  logic signed [START_W-1:0] start_y,
  input  logic signed [START_W-1:0] start_z,
  input  logic signed [DIR_W-1:0]   dir_x,
  input  logic signed [DIR_W-1:0]   dir_y,
  input  logic signed [DIR_W-1:0]   dir_z,
  input  logic [THR_W-1:0]          hit_threshold,
  input  logic [STEPS_W-1:0]        max_steps,
  input  logic [SIZE_W-1:0]         size_x,
  input  logic [SIZE_W-1:0]         size_y,
  input  logic [SIZE_W-1:0]         size_z,
  input  logic                      m_tready,
  output logic                      m_tvalid,
  output logic                      hit,
  output logic signed [HIT_W-1:0]   hit_x,
  output logic signed [HIT_W-1:0]   hit_y,
  output logic signed [HIT_W-1:0]   hit_z,
  output logic [VALUE_W-1:0]        hit_value
);

  localparam int AW    = $clog2(VOL_DIM);
  localparam int RAM_D = 1 << (3 * AW);
  localparam int SZW   = $clog2(VOL_DIM + 1);
  localparam int SW    = $clog2(STEP_LIMIT + 1);
  localparam int ACC_W = (SW + 17 > 27) ? SW + 17 : 27;
  localparam int IDX_W = ACC_W - FRAC_W;
  localparam int CW    = (VOXEL_BITS > THR_W) ? VOXEL_BITS : THR_W;

  // per-axis working registers
  logic signed [ACC_W-1:0]   acc   [3];
  logic signed [HIT_W-1:0]   org   [3];
  logic signed [HIT_W-1:0]   smp   [3];
  logic signed [IDX_W-1:0]   idx   [3];
  logic signed [START_W-1:0] start [3];
  logic signed [DIR_W-1:0]   dir   [3];
  logic [SIZE_W-1:0]         size  [3];
  logic [SZW-1:0]            lim   [3];

  logic [SW-1:0]          left;
  logic [SW-1:0]          steps_eff;
  logic                   pend;
  logic                   inb;
  logic                   issue;
  logic                   wr_ok;
  logic                   vox_gt;
  logic                   ram_en;
  logic [3*AW-1:0]        ram_addr;
  logic [3*AW-1:0]        rd_addr;
  logic [3*AW-1:0]        wr_addr;
  logic [VOXEL_BITS-1:0]  ram_wdata;
  logic [VOXEL_BITS-1:0]  ram_rdata;

  assign start = '{start_x, start_y, start_z};
  assign dir   = '{dir_x, dir_y, dir_z};
  assign size  = '{size_x, size_y, size_z};

  // clamp sizes and step count to the build limits
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lim[a] = (32'(size[a]) > VOL_DIM) ? SZW'(VOL_DIM) : SZW'(size[a]);
    end
    steps_eff = (32'(max_steps) > STEP_LIMIT) ? SW'(STEP_LIMIT) : SW'(max_steps);
  end

  // floored sample index and bounds test
  always_comb begin
    inb = 1'b1;
    for (int a = 0; a < 3; a++) begin
      idx[a] = acc[a][ACC_W-1:FRAC_W];
      inb    = inb && (idx[a] > 0) && (idx[a] < $signed(IDX_W'(lim[a])));
    end
    rd_addr = {AW'(idx[0]), AW'(idx[1]), AW'(idx[2])};
  end

  // voxel write decode
  assign wr_ok   = (32'(wr_x) < VOL_DIM) && (32'(wr_y) < VOL_DIM) && (32'(wr_z) < VOL_DIM);
  assign wr_addr = {AW'(wr_x), AW'(wr_y), AW'(wr_z)};

  // memory port sharing: writes only while idle, reads only while casting
  assign issue     = cmd.run && (left != '0);
  assign ram_en    = (cmd.write && wr_ok) || (issue && inb);
  assign ram_addr  = cmd.write ? wr_addr : rd_addr;
  assign ram_wdata = VOXEL_BITS'(wr_value);

  vrfh_ram #(
    .WIDTH (VOXEL_BITS),
    .DEPTH (RAM_D)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (cmd.write),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // status
  assign vox_gt       = CW'(ram_rdata) > CW'(hit_threshold);
  assign sts.hit      = pend && vox_gt;
  assign sts.done     = (left == '0) && !pend;
  assign sts.out_free = !m_tvalid || m_tready;

  // ray stepping
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int a = 0; a < 3; a++) begin
        acc[a] <= {{(ACC_W - START_W - 6){start[a][START_W-1]}}, start[a], 6'b0};
        org[a] <= start[a][START_W-1:START_FRAC_W];
      end
      left <= steps_eff;
    end else if (issue) begin
      for (int a = 0; a < 3; a++) begin
        acc[a] <= acc[a] + {{(ACC_W - DIR_W){dir[a][DIR_W-1]}}, dir[a]};
        smp[a] <= idx[a][HIT_W-1:0];
      end
      left <= left - 1'b1;
    end
  end

  // sample in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.start) begin
      pend <= 1'b0;
    end else if (cmd.run) begin
      pend <= issue && inb;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      hit       <= sts.hit;
      hit_x     <= sts.hit ? smp[0] : org[0];
      hit_y     <= sts.hit ? smp[1] : org[1];
      hit_z     <= sts.hit ? smp[2] : org[2];
      hit_value <= sts.hit ? VALUE_W'(ram_rdata) : '0;
    end
  end

endmodule

// ----- rtl/voxel_ray_first_hit_unit.sv -----
`timescale 1ns / 1ps
// voxel write: one request per cycle while no cast is running, no result
// ray cast: one result per request, from the first sampled voxel above threshold, else
//   from the start point; steps = max_steps clamped to STEP_LIMIT, with one volume read
//   per in-bounds step
// a new request is taken once the cast result is in the output register
// reset: synchronous, active high; clears control and loads register defaults,
//   volume contents stay undefined until written
module voxel_ray_first_hit_unit import vrfh_pkg::*; #(
  parameter int VOL_DIM    = DEF_VOL_DIM,
  parameter int STEP_LIMIT = DEF_STEP_LIMIT,
  parameter int VOXEL_BITS = DEF_VOXEL_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // wr_x, wr_y, wr_z, wr_value, start_x, start_y, start_z, zero pad
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // req_type
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // hit_x, hit_y, hit_z, hit_value, zero pad
  output logic [M_TDATA_W-1:0]  m_tdata,
  // hit
  output logic                  m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic signed [DIR_W-1:0]   dir_x;
  logic signed [DIR_W-1:0]   dir_y;
  logic signed [DIR_W-1:0]   dir_z;
  logic [THR_W-1:0]          hit_threshold;
  logic [STEPS_W-1:0]        max_steps;
  logic [SIZE_W-1:0]         size_x;
  logic [SIZE_W-1:0]         size_y;
  logic [SIZE_W-1:0]         size_z;

  logic signed [HIT_W-1:0]   hit_x;
  logic signed [HIT_W-1:0]   hit_y;
  logic signed [HIT_W-1:0]   hit_z;
  logic [VALUE_W-1:0]        hit_value;

  cmd_t cmd;
  sts_t sts;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_x         <= RST_DIR_X;
      dir_y         <= RST_DIR_Y;
      dir_z         <= RST_DIR_Z;
      hit_threshold <= RST_THR;
      max_steps     <= RST_STEPS;
      size_x        <= RST_SIZE;
      size_y        <= RST_SIZE;
      size_z        <= RST_SIZE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DIR_X:  dir_x         <= cfg_data[DIR_W-1:0];
        CFG_DIR_Y:  dir_y         <= cfg_data[DIR_W-1:0];
        CFG_DIR_Z:  dir_z         <= cfg_data[DIR_W-1:0];
        CFG_THR:    hit_threshold <= cfg_data[THR_W-1:0];
        CFG_STEPS:  max_steps     <= cfg_data[STEPS_W-1:0];
        CFG_SIZE_X: size_x        <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Y: size_y        <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Z: size_z        <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  vrfh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .req_kind (s_tuser),
    .sts      (sts),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  vrfh_datapath #(
    .VOL_DIM    (VOL_DIM),
    .STEP_LIMIT (STEP_LIMIT),
    .VOXEL_BITS (VOXEL_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .wr_x          (s_tdata[5:0]),
    .wr_y          (s_tdata[11:6]),
    .wr_z          (s_tdata[17:12]),
    .wr_value      (s_tdata[25:18]),
    .start_x       (s_tdata[45:26]),
    .start_y       (s_tdata[65:46]),
    .start_z       (s_tdata[85:66]),
    .dir_x         (dir_x),
    .dir_y         (dir_y),
    .dir_z         (dir_z),
    .hit_threshold (hit_threshold),
    .max_steps     (max_steps),
    .size_x        (size_x),
    .size_y        (size_y),
    .size_z        (size_z),
    .m_tready      (m_tready),
    .m_tvalid      (m_tvalid),
    .hit           (m_tuser),
    .hit_x         (hit_x),
    .hit_y         (hit_y),
    .hit_z         (hit_z),
    .hit_value     (hit_value)
  );

  // result packing
  assign m_tdata = {4'b0, hit_value, hit_z, hit_y, hit_x};

  // a cast request blocks further requests
  a_cast_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == REQ_CAST)) |=> !s_tready)
    else $error("request taken right after a cast request");

  // a miss reports a zero value
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (hit_value == '0))
    else $error("miss with nonzero value");

  // a hit has every coordinate above zero
  a_hit_inside: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> ((hit_x > 0) && (hit_y > 0) && (hit_z > 0)))
    else $error("hit outside the volume");

  // a hit value is above the threshold
  a_hit_thr: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser && (VOXEL_BITS <= VALUE_W)) |-> (hit_value > hit_threshold))
    else $error("hit value not above threshold");

endmodule

// ----- sim/vrfh_hit_checker.sv -----
`timescale 1ns / 1ps
module vrfh_hit_checker
  import vrfh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // wr_x, wr_y, wr_z, wr_value, start_x, start_y, start_z, zero pad
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // req_type
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // hit_x, hit_y, hit_z, hit_value, zero pad
  input  logic [M_TDATA_W-1:0]  m_tdata,
  // hit
  input  logic                  m_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    due_count,
  output int                    fail_count
);

  localparam int VOL = DEF_VOL_DIM;
  localparam int VOXELS = VOL * VOL * VOL;
  localparam int START_LO = 3 * COORD_W + VALUE_W;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic                    hit;
    logic signed [HIT_W-1:0] x;
    logic signed [HIT_W-1:0] y;
    logic signed [HIT_W-1:0] z;
    logic [VALUE_W-1:0]      value;
  } ray_outcome_t;

  // local copy of the register file
  logic signed [DIR_W-1:0] dir_x, dir_y, dir_z;
  logic [THR_W-1:0]        thr;
  logic [STEPS_W-1:0]      steps;
  logic [SIZE_W-1:0]       ext_x, ext_y, ext_z;

  logic [VALUE_W-1:0] voxels [0:VOXELS-1];
  ray_outcome_t       outcomes_due [$];
  int                 mismatches = 0;

  // voxel index along one axis, floored from the Q.14 sum
  function automatic longint axis_index(input logic signed [START_W-1:0] p,
                                        input logic signed [DIR_W-1:0] d,
                                        input longint lam);
    return ((longint'(p) <<< (FRAC_W - START_FRAC_W)) + longint'(d) * lam) >>> FRAC_W;
  endfunction

  function automatic longint span_of(input logic [SIZE_W-1:0] s);
    return (s > VOL) ? longint'(VOL) : longint'(s);
  endfunction

  // walk the ray and stop at the first voxel above threshold
  function automatic ray_outcome_t predict_first_hit(input logic signed [START_W-1:0] px,
                                                     input logic signed [START_W-1:0] py,
                                                     input logic signed [START_W-1:0] pz);
    ray_outcome_t res;
    longint n, lam, rx, ry, rz;
    int slot;
    res.hit = 1'b0;
    res.value = '0;
    res.x = HIT_W'(longint'(px) >>> START_FRAC_W);
    res.y = HIT_W'(longint'(py) >>> START_FRAC_W);
    res.z = HIT_W'(longint'(pz) >>> START_FRAC_W);
    n = (steps > DEF_STEP_LIMIT) ? longint'(DEF_STEP_LIMIT) : longint'(steps);
    for (lam = 0; lam < n; lam++) begin
      rx = axis_index(px, dir_x, lam);
      ry = axis_index(py, dir_y, lam);
      rz = axis_index(pz, dir_z, lam);
      if (rx > 0 && ry > 0 && rz > 0 &&
          rx < span_of(ext_x) && ry < span_of(ext_y) && rz < span_of(ext_z)) begin
        slot = int'((rx * VOL + ry) * VOL + rz);
        if (voxels[slot] > thr) begin
          res.hit = 1'b1;
          res.value = voxels[slot];
          res.x = HIT_W'(rx);
          res.y = HIT_W'(ry);
          res.z = HIT_W'(rz);
          break;
        end
      end
    end
    return res;
  endfunction

  // watch all three channels at each rising edge
  always @(posedge clk) begin : watch
    ray_outcome_t got, want;
    if (rst) begin
      dir_x = RST_DIR_X;
      dir_y = RST_DIR_Y;
      dir_z = RST_DIR_Z;
      thr = RST_THR;
      steps = RST_STEPS;
      ext_x = RST_SIZE;
      ext_y = RST_SIZE;
      ext_z = RST_SIZE;
      outcomes_due.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DIR_X:  dir_x = cfg_data;
          CFG_DIR_Y:  dir_y = cfg_data;
          CFG_DIR_Z:  dir_z = cfg_data;
          CFG_THR:    thr = cfg_data[THR_W-1:0];
          CFG_STEPS:  steps = cfg_data[STEPS_W-1:0];
          CFG_SIZE_X: ext_x = cfg_data[SIZE_W-1:0];
          CFG_SIZE_Y: ext_y = cfg_data[SIZE_W-1:0];
          CFG_SIZE_Z: ext_z = cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
      // results against the oldest prediction
      if (m_tvalid && m_tready) begin
        got.hit = m_tuser;
        got.x = m_tdata[0 +: HIT_W];
        got.y = m_tdata[HIT_W +: HIT_W];
        got.z = m_tdata[2 * HIT_W +: HIT_W];
        got.value = m_tdata[3 * HIT_W +: VALUE_W];
        if (outcomes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: unexpected result hit=%0d x=%0d y=%0d z=%0d value=%0d",
                     $realtime, got.hit, got.x, got.y, got.z, got.value);
        end else begin
          want = outcomes_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display({"%0t: result mismatch, expected hit=%0d x=%0d y=%0d z=%0d value=%0d,",
                        " got hit=%0d x=%0d y=%0d z=%0d value=%0d"},
                       $realtime, want.hit, want.x, want.y, want.z, want.value,
                       got.hit, got.x, got.y, got.z, got.value);
          end
        end
      end
      // accepted requests, volume index is x then y then z from the top bits down
      if (s_tvalid && s_tready) begin
        if (s_tuser == REQ_WRITE)
          voxels[{s_tdata[0 +: COORD_W], s_tdata[COORD_W +: COORD_W],
                  s_tdata[2 * COORD_W +: COORD_W]}] = s_tdata[3 * COORD_W +: VALUE_W];
        else
          outcomes_due.push_back(predict_first_hit(s_tdata[START_LO +: START_W],
                                                   s_tdata[START_LO + START_W +: START_W],
                                                   s_tdata[START_LO + 2 * START_W +: START_W]));
      end
    end
    due_count <= outcomes_due.size();
    fail_count <= mismatches;
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import vrfh_pkg::*;

  localparam int     VOL = DEF_VOL_DIM;
  localparam int     VOXELS = VOL * VOL * VOL;
  localparam int     ITEM_TARGET = 950;
  localparam int     SETTLE_CYCLES = 10;
  localparam int     TAIL_CYCLES = DEF_STEP_LIMIT + 8;
  localparam longint RUN_LIMIT_NS = 80_000_000;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    due_count;
  int                    fail_count;

  bit no_gaps = 1'b0;
  int requests_sent = 0;

  // register and volume copies used to steer the rays
  logic signed [DIR_W-1:0] ray_dx = RST_DIR_X;
  logic signed [DIR_W-1:0] ray_dy = RST_DIR_Y;
  logic signed [DIR_W-1:0] ray_dz = RST_DIR_Z;
  logic [THR_W-1:0]        ray_thr = RST_THR;
  logic [STEPS_W-1:0]      ray_steps = RST_STEPS;
  logic [SIZE_W-1:0]       ray_ext_x = RST_SIZE;
  logic [SIZE_W-1:0]       ray_ext_y = RST_SIZE;
  logic [SIZE_W-1:0]       ray_ext_z = RST_SIZE;
  logic [VALUE_W-1:0]      vox_level [0:VOXELS-1];
  bit                      vox_known [0:VOXELS-1];

  voxel_ray_first_hit_unit uut (.*);
  vrfh_hit_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_top: errors");
    $finish;
  end

  // result side: random hold-off after each accepted result
  initial begin : result_sink
    int hold;
    m_tready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready)
        hold = no_gaps ? 0 : $urandom_range(0, 4);
      @(negedge clk);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic longint clamp_extent(input logic [SIZE_W-1:0] s);
    return (s > VOL) ? longint'(VOL) : longint'(s);
  endfunction

  function automatic longint axis_cell(input logic signed [START_W-1:0] p,
                                       input logic signed [DIR_W-1:0] d,
                                       input longint lam);
    return ((longint'(p) <<< (FRAC_W - START_FRAC_W)) + longint'(d) * lam) >>> FRAC_W;
  endfunction

  function automatic logic [S_TDATA_W-1:0] pack_request(
    input logic [COORD_W-1:0] wx, input logic [COORD_W-1:0] wy,
    input logic [COORD_W-1:0] wz, input logic [VALUE_W-1:0] wv,
    input logic [START_W-1:0] px, input logic [START_W-1:0] py,
    input logic [START_W-1:0] pz);
    return S_TDATA_W'({pz, py, px, wv, wz, wy, wx});
  endfunction

  // mostly at or below threshold so that rays travel a while before a hit
  function automatic logic [VALUE_W-1:0] draw_level();
    if (ray_thr == 8'd255 || $urandom_range(0, 4) != 0)
      return VALUE_W'($urandom_range(0, ray_thr));
    return VALUE_W'($urandom_range(int'(ray_thr) + 1, 255));
  endfunction

  function automatic logic [DIR_W-1:0] draw_dir();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return '0;
      default: return DIR_W'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] draw_extent();
    case ($urandom_range(0, 7))
      0: return 7'd64;
      1: return 7'd1;
      default: return SIZE_W'($urandom_range(2, 64));
    endcase
  endfunction

  // start near the volume, sometimes anywhere in the field range
  function automatic logic [START_W-1:0] draw_start(input logic [SIZE_W-1:0] ext);
    if ($urandom_range(0, 5) == 0)
      return START_W'($urandom);
    return START_W'($urandom_range(0, 32'(clamp_extent(ext) * 256 + 1023)) - 512);
  endfunction

  // one request on the input stream
  task automatic send_request(input logic kind, input logic [S_TDATA_W-1:0] data);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= data;
    do begin
      @(posedge clk);
    end while (!s_tready);
    requests_sent++;
  endtask

  task automatic put_voxel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic [COORD_W-1:0] z, input logic [VALUE_W-1:0] v);
    vox_level[{x, y, z}] = v;
    vox_known[{x, y, z}] = 1'b1;
    send_request(REQ_WRITE, pack_request(x, y, z, v, START_W'($urandom),
                                         START_W'($urandom), START_W'($urandom)));
  endtask

  // fill unwritten voxels the ray will read, then cast it
  task automatic cast_ray(input logic signed [START_W-1:0] px,
                          input logic signed [START_W-1:0] py,
                          input logic signed [START_W-1:0] pz);
    longint n, lam, rx, ry, rz;
    int slot;
    n = (ray_steps > DEF_STEP_LIMIT) ? longint'(DEF_STEP_LIMIT) : longint'(ray_steps);
    for (lam = 0; lam < n; lam++) begin
      rx = axis_cell(px, ray_dx, lam);
      ry = axis_cell(py, ray_dy, lam);
      rz = axis_cell(pz, ray_dz, lam);
      if (rx > 0 && ry > 0 && rz > 0 && rx < clamp_extent(ray_ext_x) &&
          ry < clamp_extent(ray_ext_y) && rz < clamp_extent(ray_ext_z)) begin
        slot = int'((rx * VOL + ry) * VOL + rz);
        if (!vox_known[slot])
          put_voxel(COORD_W'(rx), COORD_W'(ry), COORD_W'(rz), draw_level());
        if (vox_level[slot] > ray_thr)
          break;
      end
    end
    send_request(REQ_CAST, pack_request(COORD_W'($urandom), COORD_W'($urandom),
                                        COORD_W'($urandom), VALUE_W'($urandom),
                                        px, py, pz));
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    do begin
      @(posedge clk);
    end while (due_count != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_DIR_X:  ray_dx = val;
      CFG_DIR_Y:  ray_dy = val;
      CFG_DIR_Z:  ray_dz = val;
      CFG_THR:    ray_thr = val[THR_W-1:0];
      CFG_STEPS:  ray_steps = val[STEPS_W-1:0];
      CFG_SIZE_X: ray_ext_x = val[SIZE_W-1:0];
      CFG_SIZE_Y: ray_ext_y = val[SIZE_W-1:0];
      CFG_SIZE_Z: ray_ext_z = val[SIZE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // full register set, written only once the unit is idle
  task automatic apply_config(input logic [DIR_W-1:0] dx, input logic [DIR_W-1:0] dy,
                              input logic [DIR_W-1:0] dz, input logic [THR_W-1:0] thr,
                              input logic [STEPS_W-1:0] n, input logic [SIZE_W-1:0] ex,
                              input logic [SIZE_W-1:0] ey, input logic [SIZE_W-1:0] ez);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_DIR_X, dx);
    write_reg(CFG_DIR_Y, dy);
    write_reg(CFG_DIR_Z, dz);
    write_reg(CFG_THR, CFG_DATA_W'(thr));
    write_reg(CFG_STEPS, CFG_DATA_W'(n));
    write_reg(CFG_SIZE_X, CFG_DATA_W'(ex));
    write_reg(CFG_SIZE_Y, CFG_DATA_W'(ey));
    write_reg(CFG_SIZE_Z, CFG_DATA_W'(ez));
  endtask

  initial begin : stimulus
    int phase, span, k;
    logic [THR_W-1:0] thr_pick;
    logic [STEPS_W-1:0] steps_pick;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = REQ_WRITE;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // corner writes, then rays at reset settings
    put_voxel(0, 0, 0, 0);
    put_voxel(63, 63, 63, 255);
    // start on index zero, never sampled
    cast_ray(0, 0, 0);
    // value equal to threshold is passed over, one above hits
    put_voxel(15, 5, 7, 70);
    put_voxel(16, 5, 7, 71);
    cast_ray(15 * 256, 5 * 256 + 128, 7 * 256 + 128);
    // top edge of the volume is still inside
    put_voxel(63, 30, 30, 200);
    cast_ray(63 * 256 + 128, 30 * 256 + 128, 30 * 256 + 128);
    // field extremes and a negative fraction floor to the start point
    cast_ray(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF);
    cast_ray(20'sh80000, 20'sh80000, 20'sh80000);
    cast_ray(-1, -1, -1);
    cast_ray(10 * 256 + 128, 5 * 256 + 64, 7 * 256 + 192);

    // unit volume lets nothing in; single step with zero threshold
    apply_config(16384, -16384, -16384, 0, 1, 1, 1, 1);
    cast_ray(384, 384, 384);
    apply_config(-16384, 16384, -16384, 0, 1, 64, 64, 64);
    cast_ray(10 * 256 + 128, 5 * 256 + 64, 7 * 256 + 192);
    // zero steps, zero size and oversize extent
    apply_config(16384, 0, 0, 70, 0, 127, 0, 64);
    cast_ray(10 * 256 + 128, 5 * 256 + 64, 7 * 256 + 192);
    // step count above the limit, slow diagonal ray
    apply_config(40, 40, 40, 100, 1023, 127, 127, 127);
    cast_ray(486, 486, 486);
    cast_ray(3000, 2000, 1000);

    // random phases, each with its own settings
    phase = 0;
    while (requests_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 15))
        0: thr_pick = 8'd0;
        1: thr_pick = 8'd255;
        default: thr_pick = THR_W'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 7))
        0: steps_pick = 10'd512;
        1: steps_pick = 10'd1;
        default: steps_pick = STEPS_W'($urandom_range(1, 512));
      endcase
      apply_config(draw_dir(), draw_dir(), draw_dir(), thr_pick, steps_pick,
                   draw_extent(), draw_extent(), draw_extent());
      no_gaps = ($urandom_range(0, 3) == 0);
      span = $urandom_range(30, 80);
      for (k = 0; k < span && requests_sent < ITEM_TARGET; k++) begin
        // every other phase, hold off mid-way until the unit has caught up
        if (phase % 2 == 1 && k == span / 2)
          drain_results();
        if ($urandom_range(0, 4) == 0)
          put_voxel(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                    VALUE_W'($urandom));
        else
          cast_ray(draw_start(ray_ext_x), draw_start(ray_ext_y), draw_start(ray_ext_z));
      end
      phase++;
    end

    // let the last results out and watch for strays
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && due_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/vrfh_pkg.sv
rtl/vrfh_ram.sv
rtl/vrfh_ctrl.sv
rtl/vrfh_datapath.sv
rtl/voxel_ray_first_hit_unit.sv
sim/vrfh_hit_checker.sv
sim/tb_top.sv
